FILE: design/mjavi_pkg.sv
// Shared types, command codes and header constants for the MJPEG AVI stream muxer.
// No dependencies; used by mjavi_div and mjpeg_avi_stream_muxer_core.
`default_nettype none

package mjavi_pkg;

	// Command opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BEGIN = 2'd1;
	localparam logic [1:0] OP_DATA  = 2'd2;
	localparam logic [1:0] OP_CLOSE = 2'd3;

	// Register indexes on the config port
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RATE   = 2'd2;

	// Reset values of the geometry registers
	localparam logic [15:0] RST_WIDTH  = 16'd640;
	localparam logic [15:0] RST_HEIGHT = 16'd480;
	localparam logic [9:0]  RST_RATE   = 10'd15;

	// Dividend for microseconds per frame
	localparam int          QUOT_W       = 20;
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	// Header layout
	localparam logic [5:0] HDR_LAST = 6'd55;

	// Patch offsets and arithmetic
	localparam logic [7:0]  OFS_MOVI   = 8'd216;
	localparam logic [7:0]  OFS_RIFF   = 8'd4;
	localparam logic [7:0]  OFS_FRAMES = 8'd48;
	localparam logic [31:0] MOVI_BIAS  = 32'd4;
	localparam logic [31:0] RIFF_BIAS  = 32'd216;   // 224 header bytes less 8

	// Four-character codes, first character in the low byte
	localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
	localparam logic [31:0] FCC_AVI  = 32'h2049_5641;
	localparam logic [31:0] FCC_LIST = 32'h5453_494C;
	localparam logic [31:0] FCC_HDRL = 32'h6C72_6468;
	localparam logic [31:0] FCC_AVIH = 32'h6869_7661;
	localparam logic [31:0] FCC_STRL = 32'h6C72_7473;
	localparam logic [31:0] FCC_STRH = 32'h6872_7473;
	localparam logic [31:0] FCC_VIDS = 32'h7364_6976;
	localparam logic [31:0] FCC_MJPG = 32'h4750_4A4D;
	localparam logic [31:0] FCC_STRF = 32'h6672_7473;
	localparam logic [31:0] FCC_MOVI = 32'h6976_6F6D;
	localparam logic [31:0] FCC_00DC = 32'h6364_3030;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} seq_state_t;

	// What the current item emits
	typedef enum logic [2:0] {
		KIND_ERR,
		KIND_HDR,
		KIND_BEGIN,
		KIND_DATA,
		KIND_CLOSE
	} item_kind_t;

	// One 32-bit word of the 224-byte file header
	function automatic logic [31:0] hdr_word(
		input logic [5:0]  idx,
		input logic [15:0] w,
		input logic [15:0] h,
		input logic [9:0]  fps,
		input logic [19:0] usec,
		input logic [31:0] area3
	);
		logic [31:0] v;
		v = 32'd0;
		case (idx)
			6'd0:  v = FCC_RIFF;
			6'd2:  v = FCC_AVI;
			6'd3:  v = FCC_LIST;
			6'd4:  v = 32'd192;
			6'd5:  v = FCC_HDRL;
			6'd6:  v = FCC_AVIH;
			6'd7:  v = 32'd56;
			6'd8:  v = {12'd0, usec};
			6'd14: v = 32'd1;
			6'd16: v = {16'd0, w};
			6'd17: v = {16'd0, h};
			6'd22: v = FCC_LIST;
			6'd23: v = 32'd116;
			6'd24: v = FCC_STRL;
			6'd25: v = FCC_STRH;
			6'd26: v = 32'd56;
			6'd27: v = FCC_VIDS;
			6'd28: v = FCC_MJPG;
			6'd32: v = 32'd1;
			6'd33: v = {22'd0, fps};
			6'd37: v = 32'hFFFF_FFFF;
			6'd40: v = {h, w};
			6'd41: v = FCC_STRF;
			6'd42: v = 32'd40;
			6'd43: v = 32'd40;
			6'd44: v = {16'd0, w};
			6'd45: v = {16'd0, h};
			6'd46: v = 32'h0018_0001;     // one plane, 24 bits per pixel
			6'd47: v = FCC_MJPG;
			6'd48: v = area3;
			6'd53: v = FCC_LIST;
			6'd55: v = FCC_MOVI;
			default: v = 32'd0;           // placeholders and reserved fields
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: design/mjpeg_avi_stream_muxer_core.sv
// Top level of the MJPEG-in-AVI container writer: command decode, stream state, output beats.
// Depends on mjavi_pkg and mjavi_div.
//
// The block takes one command beat at a time and is stalled until that command's output
// beats have all been generated into the output register. A start command runs the
// restoring divider for 1000000/frame_rate and then emits the 56 header words, one per
// cycle while the output is not stalled. Begin frame emits two words, a data word one
// beat, or two when the odd-length pad follows, a close three patch words, and an error
// command one status beat. The output register holds one finished beat, so a new command
// is taken while it waits; downstream stall only delays the emission of further words.
// Configuration is written through cfg_we/cfg_index/cfg_data; index 3 is ignored.
`default_nettype none

module mjpeg_avi_stream_muxer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// command channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] frame_len,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  data_bytes,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      out_word,
	output logic [2:0]       out_bytes,
	output logic             is_patch,
	output logic [7:0]       patch_offset,
	output logic             status,
	output logic             last
);

	// Config registers
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [9:0]  rate_q;

	// Stream state
	logic        started_q;
	logic        active_q;
	logic [31:0] left_q;
	logic        odd_q;
	logic [31:0] movi_q;
	logic [31:0] frames_q;

	// Current item
	mjavi_pkg::seq_state_t st_q, st_d;
	mjavi_pkg::item_kind_t kind_q, kind_d;
	logic [5:0]  idx_q;
	logic [5:0]  last_idx_q, last_idx_d;
	logic [31:0] len_q;
	logic [31:0] dword_q;
	logic [2:0]  nb_q;
	logic [31:0] prod_q;
	logic [31:0] area_q;

	// Output register
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_bytes_q;
	logic        is_patch_q;
	logic [7:0]  patch_offset_q;
	logic        status_q;
	logic        last_q;

	// Control
	logic        accept;
	logic        emit;
	logic        slot_free;
	logic        item_err;
	logic        div_start;
	logic        div_done;
	logic [19:0] div_quot;
	logic        is_last;

	// Data-word decode
	logic [31:0] masked;
	logic [31:0] left_next;

	// Generated beat
	logic [31:0] g_word;
	logic [2:0]  g_bytes;
	logic        g_patch;
	logic [7:0]  g_offset;
	logic        g_status;

	mjavi_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (rate_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign is_last   = idx_q == last_idx_q;
	assign left_next = left_q - {29'd0, data_bytes};

	// Keep only the valid bytes of a data word
	always_comb begin
		case (data_bytes)
			3'd1:    masked = {24'd0, data_word[7:0]};
			3'd2:    masked = {16'd0, data_word[15:0]};
			3'd3:    masked = {8'd0, data_word[23:0]};
			default: masked = data_word;
		endcase
	end

	// Command checks
	always_comb begin
		unique case (opcode)
			mjavi_pkg::OP_START: item_err = started_q || (width_q == 16'd0)
				|| (height_q == 16'd0) || (rate_q == 10'd0);
			mjavi_pkg::OP_BEGIN: item_err = !started_q || active_q || (frame_len == 32'd0);
			mjavi_pkg::OP_DATA:  item_err = !active_q || (data_bytes == 3'd0)
				|| (data_bytes > 3'd4) || ({29'd0, data_bytes} > left_q);
			mjavi_pkg::OP_CLOSE: item_err = !started_q || active_q;
			default:             item_err = 1'b1;
		endcase
	end

	// Sequencer: next state, item kind, beat count
	always_comb begin
		st_d       = st_q;
		kind_d     = kind_q;
		last_idx_d = last_idx_q;
		in_stall   = st_q != mjavi_pkg::ST_IDLE;
		div_start  = 1'b0;
		emit       = 1'b0;
		unique case (st_q)
			mjavi_pkg::ST_IDLE: begin
				if (in_valid) begin
					st_d = mjavi_pkg::ST_EMIT;
					if (item_err) begin
						kind_d     = mjavi_pkg::KIND_ERR;
						last_idx_d = 6'd0;
					end else begin
						unique case (opcode)
							mjavi_pkg::OP_START: begin
								kind_d     = mjavi_pkg::KIND_HDR;
								last_idx_d = mjavi_pkg::HDR_LAST;
								div_start  = 1'b1;
								st_d       = mjavi_pkg::ST_DIV;
							end
							mjavi_pkg::OP_BEGIN: begin
								kind_d     = mjavi_pkg::KIND_BEGIN;
								last_idx_d = 6'd1;
							end
							mjavi_pkg::OP_DATA: begin
								kind_d     = mjavi_pkg::KIND_DATA;
								last_idx_d = {5'd0, (left_next == 32'd0) && odd_q};
							end
							default: begin
								kind_d     = mjavi_pkg::KIND_CLOSE;
								last_idx_d = 6'd2;
							end
						endcase
					end
				end
			end
			mjavi_pkg::ST_DIV: begin
				if (div_done) begin
					st_d = mjavi_pkg::ST_EMIT;
				end
			end
			mjavi_pkg::ST_EMIT: begin
				if (slot_free) begin
					emit = 1'b1;
					if (is_last) begin
						st_d = mjavi_pkg::ST_IDLE;
					end
				end
			end
			default: st_d = mjavi_pkg::ST_IDLE;
		endcase
	end

	// Beat generator
	always_comb begin
		g_word   = 32'd0;
		g_bytes  = 3'd4;
		g_patch  = 1'b0;
		g_offset = 8'd0;
		g_status = 1'b0;
		case (kind_q)
			mjavi_pkg::KIND_ERR: begin
				g_bytes  = 3'd0;
				g_status = 1'b1;
			end
			mjavi_pkg::KIND_HDR: begin
				g_word = mjavi_pkg::hdr_word(idx_q, width_q, height_q, rate_q,
					div_quot, area_q);
			end
			mjavi_pkg::KIND_BEGIN: begin
				g_word = (idx_q == 6'd0) ? mjavi_pkg::FCC_00DC : len_q;
			end
			mjavi_pkg::KIND_DATA: begin
				// second beat is the zero pad byte of an odd frame
				if (idx_q == 6'd0) begin
					g_word  = dword_q;
					g_bytes = nb_q;
				end else begin
					g_bytes = 3'd1;
				end
			end
			default: begin
				g_patch = 1'b1;
				case (idx_q)
					6'd0: begin
						g_word   = movi_q + mjavi_pkg::MOVI_BIAS;
						g_offset = mjavi_pkg::OFS_MOVI;
					end
					6'd1: begin
						g_word   = movi_q + mjavi_pkg::RIFF_BIAS;
						g_offset = mjavi_pkg::OFS_RIFF;
					end
					default: begin
						g_word   = frames_q;
						g_offset = mjavi_pkg::OFS_FRAMES;
					end
				endcase
			end
		endcase
	end

	// Sequencer and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= mjavi_pkg::ST_IDLE;
			kind_q      <= mjavi_pkg::KIND_ERR;
			idx_q       <= 6'd0;
			last_idx_q  <= 6'd0;
			out_valid_q <= 1'b0;
			width_q     <= mjavi_pkg::RST_WIDTH;
			height_q    <= mjavi_pkg::RST_HEIGHT;
			rate_q      <= mjavi_pkg::RST_RATE;
		end else begin
			st_q       <= st_d;
			kind_q     <= kind_d;
			last_idx_q <= last_idx_d;
			if (accept) begin
				idx_q <= 6'd0;
			end else if (emit) begin
				idx_q <= idx_q + 6'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					mjavi_pkg::REG_WIDTH:  width_q  <= cfg_data;
					mjavi_pkg::REG_HEIGHT: height_q <= cfg_data;
					mjavi_pkg::REG_RATE:   rate_q   <= cfg_data[9:0];
					default: ;
				endcase
			end
		end
	end

	// Stream state, updated when a command without error is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			active_q  <= 1'b0;
			left_q    <= 32'd0;
			odd_q     <= 1'b0;
			movi_q    <= 32'd0;
			frames_q  <= 32'd0;
		end else if (accept && !item_err) begin
			unique case (opcode)
				mjavi_pkg::OP_START: begin
					started_q <= 1'b1;
					active_q  <= 1'b0;
					left_q    <= 32'd0;
					odd_q     <= 1'b0;
					movi_q    <= 32'd0;
					frames_q  <= 32'd0;
				end
				mjavi_pkg::OP_BEGIN: begin
					active_q <= 1'b1;
					left_q   <= frame_len;
					odd_q    <= frame_len[0];
					movi_q   <= movi_q + 32'd8 + frame_len + {31'd0, frame_len[0]};
				end
				mjavi_pkg::OP_DATA: begin
					left_q <= left_next;
					if (left_next == 32'd0) begin
						active_q <= 1'b0;
						odd_q    <= 1'b0;
						frames_q <= frames_q + 32'd1;
					end
				end
				default: started_q <= 1'b0;
			endcase
		end
	end

	// Item payload and header arithmetic
	always_ff @(posedge clk) begin
		if (accept) begin
			len_q   <= frame_len;
			dword_q <= masked;
			nb_q    <= data_bytes;
			prod_q  <= {16'd0, width_q} * {16'd0, height_q};
		end
		if (st_q == mjavi_pkg::ST_DIV) begin
			area_q <= prod_q + {prod_q[30:0], 1'b0};
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_word_q     <= g_word;
			out_bytes_q    <= g_bytes;
			is_patch_q     <= g_patch;
			patch_offset_q <= g_offset;
			status_q       <= g_status;
			last_q         <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_word     = out_word_q;
	assign out_bytes    = out_bytes_q;
	assign is_patch     = is_patch_q;
	assign patch_offset = patch_offset_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

`default_nettype wire

FILE: design/mjavi_div.sv
// Restoring divider: 1000000 / frame rate, one quotient bit per cycle.
// Depends on mjavi_pkg for the dividend and quotient width.
`default_nettype none

module mjavi_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [9:0]  divisor,
	output logic             done,
	output logic [19:0]      quot
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [9:0]  rem_q;
	logic [19:0] quot_q;     // dividend bits shift out, quotient bits shift in
	logic [10:0] trial;
	logic        fits;

	// One trial subtraction per cycle
	assign trial = {rem_q, quot_q[19]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(mjavi_pkg::QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= 10'd0;
			quot_q <= mjavi_pkg::USEC_PER_SEC;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= 10'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[9:0];
			end
			quot_q <= {quot_q[18:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire
